### hw/rtl/tcss_pkg.sv
`default_nettype none

package tcss_pkg;

    // default sizes of the block
    localparam int NUM_CITIES_DEF = 16;
    localparam int NUM_ROUTES_DEF = 64;
    localparam int COST_BITS_DEF  = 16;

    // field widths of the channels
    localparam int OPCODE_W   = 3;
    localparam int CITY_W     = 4;
    localparam int DIST_W     = 8;
    localparam int IND_W      = 6;
    localparam int OUT_COST_W = 16;

    // command queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // opcodes on the request channel
    localparam logic [OPCODE_W-1:0] OP_WR_DIST  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_WR_CITY  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_EVAL     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_RD_BEST  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_RST_BEST = 3'd4;

    // decoded command kinds
    typedef enum logic [2:0] {
        CMD_WR_DIST  = 3'd0,
        CMD_WR_CITY  = 3'd1,
        CMD_EVAL     = 3'd2,
        CMD_RD_BEST  = 3'd3,
        CMD_RST_BEST = 3'd4
    } cmd_kind_t;

    // one queued command
    typedef struct packed {
        cmd_kind_t           kind;
        logic [CITY_W-1:0]   from_city;
        logic [CITY_W-1:0]   to_city;
        logic [DIST_W-1:0]   distance_value;
        logic [IND_W-1:0]    individual;
        logic [CITY_W-1:0]   position;
        logic [CITY_W-1:0]   city;
        logic [CITY_W-1:0]   swap_first;
        logic [CITY_W-1:0]   swap_second;
        logic                pos_ok;
        logic                swap_ok;
    } cmd_t;

    // queue handshake between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

### hw/rtl/tcss_req_if.sv
`default_nettype none

interface tcss_req_if import tcss_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [CITY_W-1:0]     from_city;
    logic [CITY_W-1:0]     to_city;
    logic [DIST_W-1:0]     distance_value;
    logic [IND_W-1:0]      individual;
    logic [CITY_W-1:0]     position;
    logic [CITY_W-1:0]     city;
    logic [CITY_W-1:0]     swap_first;
    logic [CITY_W-1:0]     swap_second;

    modport source (
        output valid, opcode, from_city, to_city, distance_value, individual,
               position, city, swap_first, swap_second,
        input  ready
    );

    modport sink (
        input  valid, opcode, from_city, to_city, distance_value, individual,
               position, city, swap_first, swap_second,
        output ready
    );

endinterface

`default_nettype wire

### hw/rtl/tcss_rsp_if.sv
`default_nettype none

interface tcss_rsp_if import tcss_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [OUT_COST_W-1:0]   tour_cost;
    logic                    improved;
    logic [OUT_COST_W-1:0]   best_cost;
    logic [CITY_W-1:0]       best_city;

    modport source (
        output valid, tour_cost, improved, best_cost, best_city,
        input  ready
    );

    modport sink (
        input  valid, tour_cost, improved, best_cost, best_city,
        output ready
    );

endinterface

`default_nettype wire

### hw/rtl/tcss_front.sv
`default_nettype none

module tcss_front import tcss_pkg::*; #(
    parameter int NUM_CITIES = NUM_CITIES_DEF,
    parameter int NUM_ROUTES = NUM_ROUTES_DEF
) (
    tcss_req_if.sink      req,
    input  queue_status_t q_status,
    output logic          q_push,
    output cmd_t          q_cmd
);

    logic keep;

    // range checks, some shared by several opcodes
    logic fc_ok;
    logic tc_ok;
    logic ind_ok;
    logic pos_ok;
    logic city_ok;
    logic swap_ok;

    always_comb
    begin
        fc_ok   = 32'(req.from_city)   < NUM_CITIES;
        tc_ok   = 32'(req.to_city)     < NUM_CITIES;
        ind_ok  = 32'(req.individual)  < NUM_ROUTES;
        pos_ok  = 32'(req.position)    < NUM_CITIES;
        city_ok = 32'(req.city)        < NUM_CITIES;
        swap_ok = (32'(req.swap_first) < NUM_CITIES) && (32'(req.swap_second) < NUM_CITIES);
    end

    // classify the opcode, drop items that change nothing
    always_comb
    begin
        q_cmd.from_city      = req.from_city;
        q_cmd.to_city        = req.to_city;
        q_cmd.distance_value = req.distance_value;
        q_cmd.individual     = req.individual;
        q_cmd.position       = req.position;
        q_cmd.city           = req.city;
        q_cmd.swap_first     = req.swap_first;
        q_cmd.swap_second    = req.swap_second;
        q_cmd.pos_ok         = pos_ok;
        q_cmd.swap_ok        = swap_ok;
        q_cmd.kind           = CMD_WR_DIST;
        keep                 = 1'b0;
        case (req.opcode)
            OP_WR_DIST:
            begin
                q_cmd.kind = CMD_WR_DIST;
                keep       = fc_ok && tc_ok;
            end
            OP_WR_CITY:
            begin
                q_cmd.kind = CMD_WR_CITY;
                keep       = ind_ok && pos_ok && city_ok;
            end
            OP_EVAL:
            begin
                q_cmd.kind = CMD_EVAL;
                keep       = ind_ok;
            end
            OP_RD_BEST:
            begin
                q_cmd.kind = CMD_RD_BEST;
                keep       = 1'b1;
            end
            OP_RST_BEST:
            begin
                q_cmd.kind = CMD_RST_BEST;
                keep       = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // transfer whenever the queue has room
    assign req.ready = !q_status.full;
    assign q_push    = req.valid && !q_status.full && keep;

endmodule

`default_nettype wire

### hw/rtl/tcss_queue.sv
`default_nettype none

module tcss_queue import tcss_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          pop_cmd,
    output queue_status_t status
);

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tcss_back.sv
`default_nettype none

module tcss_back import tcss_pkg::*; #(
    parameter int NUM_CITIES = NUM_CITIES_DEF,
    parameter int NUM_ROUTES = NUM_ROUTES_DEF,
    parameter int COST_BITS  = COST_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  cmd_t          q_cmd,
    output logic          q_pop,
    tcss_rsp_if.source    rsp
);

    localparam int CIDX_W     = $clog2(NUM_CITIES);
    localparam int STEP_W     = $clog2(NUM_CITIES + 4);
    localparam int DIST_DEPTH = NUM_CITIES * NUM_CITIES;
    localparam int DIST_AW    = $clog2(DIST_DEPTH);
    localparam int POP_DEPTH  = NUM_ROUTES * NUM_CITIES;
    localparam int POP_AW     = (POP_DEPTH > 1) ? $clog2(POP_DEPTH) : 1;

    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    // evaluation schedule, counted in steps
    localparam logic [STEP_W-1:0] LAST_CITY_STEP = STEP_W'(NUM_CITIES);
    localparam logic [STEP_W-1:0] CLOSE_STEP     = STEP_W'(NUM_CITIES + 1);
    localparam logic [STEP_W-1:0] DONE_STEP      = STEP_W'(NUM_CITIES + 2);
    localparam logic [STEP_W-1:0] FIRST_ACC_STEP = STEP_W'(3);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EVAL   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_SWAP_A = 5'b01000,
        ST_SWAP_B = 5'b10000
    } state_t;

    // memories
    logic [DIST_W-1:0] dist_mem [DIST_DEPTH];
    logic [CITY_W-1:0] pop_mem  [POP_DEPTH];

    // sequencer state
    state_t             state_reg;
    state_t             state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [STEP_W-1:0]  arr_idx;
    logic [POP_AW-1:0]  base_reg;
    logic [POP_AW-1:0]  base_next;
    logic [CITY_W-1:0]  s1_reg;
    logic [CITY_W-1:0]  s1_next;
    logic [CITY_W-1:0]  s2_reg;
    logic [CITY_W-1:0]  s2_next;
    logic               swap_ok_reg;
    logic               swap_ok_next;

    // evaluation datapath
    logic [COST_BITS-1:0] acc_reg;
    logic [COST_BITS-1:0] acc_next;
    logic [COST_BITS:0]   acc_sum;
    logic [DIST_W-1:0]    leg;
    logic [CITY_W-1:0]    prev_city_reg;
    logic [CITY_W-1:0]    prev_city_next;
    logic [CITY_W-1:0]    first_city_reg;
    logic [CITY_W-1:0]    first_city_next;
    logic [CITY_W-1:0]    sa_reg;
    logic [CITY_W-1:0]    sa_next;
    logic [CITY_W-1:0]    sb_reg;
    logic [CITY_W-1:0]    sb_next;
    logic [CITY_W-1:0]    tmp_route_reg  [NUM_CITIES];
    logic [CITY_W-1:0]    tmp_route_next [NUM_CITIES];
    logic                 better;

    // best route
    logic [COST_BITS-1:0] best_cost_reg;
    logic [COST_BITS-1:0] best_cost_next;
    logic [CITY_W-1:0]    best_route_reg  [NUM_CITIES];
    logic [CITY_W-1:0]    best_route_next [NUM_CITIES];

    // memory ports
    logic               pop_re;
    logic [POP_AW-1:0]  pop_raddr;
    logic               pop_we;
    logic [POP_AW-1:0]  pop_waddr;
    logic [CITY_W-1:0]  pop_wdata;
    logic [CITY_W-1:0]  pop_q_reg;
    logic               dist_re;
    logic [CITY_W-1:0]  dist_a;
    logic [CITY_W-1:0]  dist_b;
    logic [DIST_AW-1:0] dist_raddr;
    logic               dist_we;
    logic [DIST_AW-1:0] dist_waddr;
    logic [DIST_W-1:0]  dist_q_reg;
    logic               d_ok_reg;
    logic               d_ok_next;

    // output register
    logic                  slot_free;
    logic                  out_load;
    logic                  out_vld_reg;
    logic [OUT_COST_W-1:0] tour_cost_reg;
    logic [OUT_COST_W-1:0] tour_cost_next;
    logic                  improved_reg;
    logic                  improved_next;
    logic [OUT_COST_W-1:0] best_cost_out_reg;
    logic [OUT_COST_W-1:0] best_cost_out_next;
    logic [CITY_W-1:0]     best_city_reg;
    logic [CITY_W-1:0]     best_city_next;

    assign slot_free = !out_vld_reg || rsp.ready;
    assign arr_idx   = step_reg - 1'b1;

    // saturating accumulate of the leg that arrives this cycle
    assign leg     = d_ok_reg ? dist_q_reg : '0;
    assign acc_sum = {1'b0, acc_reg} + (COST_BITS + 1)'(leg);
    assign better  = acc_reg < best_cost_reg;

    // leg address and city range check
    always_comb
    begin
        dist_raddr = DIST_AW'(32'(dist_a) * NUM_CITIES + 32'(dist_b));
        d_ok_next  = (32'(dist_a) < NUM_CITIES) && (32'(dist_b) < NUM_CITIES);
    end

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        step_next          = step_reg;
        base_next          = base_reg;
        s1_next            = s1_reg;
        s2_next            = s2_reg;
        swap_ok_next       = swap_ok_reg;
        acc_next           = acc_reg;
        prev_city_next     = prev_city_reg;
        first_city_next    = first_city_reg;
        sa_next            = sa_reg;
        sb_next            = sb_reg;
        tmp_route_next     = tmp_route_reg;
        best_cost_next     = best_cost_reg;
        best_route_next    = best_route_reg;
        tour_cost_next     = tour_cost_reg;
        improved_next      = improved_reg;
        best_cost_out_next = best_cost_out_reg;
        best_city_next     = best_city_reg;
        out_load           = 1'b0;
        q_pop              = 1'b0;
        pop_re             = 1'b0;
        pop_raddr          = POP_AW'(32'(base_reg) + 32'(step_reg));
        pop_we             = 1'b0;
        pop_waddr          = POP_AW'(32'(q_cmd.individual) * NUM_CITIES + 32'(q_cmd.position));
        pop_wdata          = q_cmd.city;
        dist_re            = 1'b0;
        dist_a             = prev_city_reg;
        dist_b             = pop_q_reg;
        dist_we            = 1'b0;
        dist_waddr         = DIST_AW'(32'(q_cmd.from_city) * NUM_CITIES + 32'(q_cmd.to_city));

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    case (q_cmd.kind)
                        CMD_WR_DIST:
                        begin
                            dist_we = 1'b1;
                            q_pop   = 1'b1;
                        end
                        CMD_WR_CITY:
                        begin
                            pop_we = 1'b1;
                            q_pop  = 1'b1;
                        end
                        CMD_RST_BEST:
                        begin
                            best_cost_next = COST_MAX;
                            q_pop          = 1'b1;
                        end
                        CMD_RD_BEST:
                        begin
                            if (slot_free)
                            begin
                                out_load           = 1'b1;
                                tour_cost_next     = '0;
                                improved_next      = 1'b0;
                                best_cost_out_next = OUT_COST_W'(best_cost_reg);
                                best_city_next     = q_cmd.pos_ok ?
                                    best_route_reg[CIDX_W'(q_cmd.position)] : '0;
                                q_pop              = 1'b1;
                            end
                        end
                        CMD_EVAL:
                        begin
                            base_next    = POP_AW'(32'(q_cmd.individual) * NUM_CITIES);
                            s1_next      = q_cmd.swap_first;
                            s2_next      = q_cmd.swap_second;
                            swap_ok_next = q_cmd.swap_ok;
                            acc_next     = '0;
                            step_next    = '0;
                            state_next   = ST_EVAL;
                            q_pop        = 1'b1;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end

            ST_EVAL:
            begin
                // fetch route cities in order
                if (step_reg < LAST_CITY_STEP)
                begin
                    pop_re = 1'b1;
                end
                // city of position step-1 arrives
                if ((step_reg != '0) && (step_reg <= LAST_CITY_STEP))
                begin
                    tmp_route_next[CIDX_W'(arr_idx)] = pop_q_reg;
                    if (32'(arr_idx) == 32'(s1_reg))
                    begin
                        sa_next = pop_q_reg;
                    end
                    if (32'(arr_idx) == 32'(s2_reg))
                    begin
                        sb_next = pop_q_reg;
                    end
                    if (step_reg == STEP_W'(1))
                    begin
                        first_city_next = pop_q_reg;
                    end
                    else
                    begin
                        dist_re = 1'b1;
                    end
                    prev_city_next = pop_q_reg;
                end
                // return leg to the first city
                if (step_reg == CLOSE_STEP)
                begin
                    dist_re = 1'b1;
                    dist_a  = prev_city_reg;
                    dist_b  = first_city_reg;
                end
                if (step_reg >= FIRST_ACC_STEP)
                begin
                    acc_next = acc_sum[COST_BITS] ? COST_MAX : acc_sum[COST_BITS-1:0];
                end
                step_next = step_reg + 1'b1;
                if (step_reg == DONE_STEP)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (slot_free)
                begin
                    out_load       = 1'b1;
                    tour_cost_next = OUT_COST_W'(acc_reg);
                    improved_next  = better;
                    best_city_next = '0;
                    if (better)
                    begin
                        best_cost_next     = acc_reg;
                        best_route_next    = tmp_route_reg;
                        best_cost_out_next = OUT_COST_W'(acc_reg);
                    end
                    else
                    begin
                        best_cost_out_next = OUT_COST_W'(best_cost_reg);
                    end
                    state_next = swap_ok_reg ? ST_SWAP_A : ST_IDLE;
                end
            end

            ST_SWAP_A:
            begin
                pop_we     = 1'b1;
                pop_waddr  = POP_AW'(32'(base_reg) + 32'(s1_reg));
                pop_wdata  = sb_reg;
                state_next = ST_SWAP_B;
            end

            ST_SWAP_B:
            begin
                pop_we     = 1'b1;
                pop_waddr  = POP_AW'(32'(base_reg) + 32'(s2_reg));
                pop_wdata  = sa_reg;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and best-route registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_vld_reg   <= 1'b0;
            best_cost_reg <= COST_MAX;
            for (int i = 0; i < NUM_CITIES; i++)
            begin
                best_route_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            best_cost_reg  <= best_cost_next;
            best_route_reg <= best_route_next;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg          <= base_next;
        s1_reg            <= s1_next;
        s2_reg            <= s2_next;
        swap_ok_reg       <= swap_ok_next;
        acc_reg           <= acc_next;
        prev_city_reg     <= prev_city_next;
        first_city_reg    <= first_city_next;
        sa_reg            <= sa_next;
        sb_reg            <= sb_next;
        tmp_route_reg     <= tmp_route_next;
        tour_cost_reg     <= tour_cost_next;
        improved_reg      <= improved_next;
        best_cost_out_reg <= best_cost_out_next;
        best_city_reg     <= best_city_next;
    end

    // distance table, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= q_cmd.distance_value;
        end
        if (dist_re)
        begin
            dist_q_reg <= dist_mem[dist_raddr];
            d_ok_reg   <= d_ok_next;
        end
    end

    // route population, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (pop_we)
        begin
            pop_mem[pop_waddr] <= pop_wdata;
        end
        if (pop_re)
        begin
            pop_q_reg <= pop_mem[pop_raddr];
        end
    end

    assign rsp.valid     = out_vld_reg;
    assign rsp.tour_cost = tour_cost_reg;
    assign rsp.improved  = improved_reg;
    assign rsp.best_cost = best_cost_out_reg;
    assign rsp.best_city = best_city_reg;

endmodule

`default_nettype wire

### hw/rtl/tour_cost_swap_search_unit.sv
// closed-tour cost evaluation with swap search
// req channel: one command per transfer (write distance, write route city,
//   evaluate and swap, read best city, reset best cost); unknown opcodes and
//   out-of-range writes or evaluations are taken and dropped
// rsp channel: one result per evaluate or read-best command, none otherwise
// the front decodes each request and pushes it into a two-entry command
//   queue; req stays ready until both entries are taken
// the back end runs one command at a time; an evaluate pops the queue,
//   reads the route cities one per cycle, one distance per edge and the
//   return leg, then compares once the output register is free; a swap
//   then adds two writes before the next command
// a result sits in an output register until taken; while it waits the back
//   end stalls at its next result and the queue takes requests until full,
//   then req.ready drops
// reset: best cost goes to all ones (no route yet), best route to zero,
//   queue and output empty; distance table and routes hold no value until
//   written, and no clearing pass runs
`default_nettype none

module tour_cost_swap_search_unit import tcss_pkg::*; #(
    parameter int NUM_CITIES = NUM_CITIES_DEF,
    parameter int NUM_ROUTES = NUM_ROUTES_DEF,
    parameter int COST_BITS  = COST_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tcss_req_if.sink   req,
    tcss_rsp_if.source rsp
);

    queue_status_t q_status;
    logic          q_push;
    cmd_t          q_push_cmd;
    logic          q_pop;
    cmd_t          q_pop_cmd;

    // decode and filter requests
    tcss_front #(
        .NUM_CITIES (NUM_CITIES),
        .NUM_ROUTES (NUM_ROUTES)
    ) u_front (
        .req      (req),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    // command queue
    tcss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .status   (q_status)
    );

    // execution sequencer and storage
    tcss_back #(
        .NUM_CITIES (NUM_CITIES),
        .NUM_ROUTES (NUM_ROUTES),
        .COST_BITS  (COST_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_cmd    (q_pop_cmd),
        .q_pop    (q_pop),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

### dv/tcss_tour_checker.sv
`default_nettype none

module tcss_tour_checker import tcss_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    tcss_req_if   req,
    tcss_rsp_if   rsp,
    output int    mismatches,
    output int    pending,
    output int    evals_seen,
    output int    reads_seen,
    output int    gains_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     NCITY     = NUM_CITIES_DEF;
    localparam int     NROUTE    = NUM_ROUTES_DEF;
    localparam longint COST_MAX  = (longint'(1) << COST_BITS_DEF) - 1;
    localparam int     PRINT_CAP = 100;

    // one response as the block should return it
    typedef struct packed {
        logic [OUT_COST_W-1:0] tour_cost;
        logic                  improved;
        logic [OUT_COST_W-1:0] best_cost;
        logic [CITY_W-1:0]     best_city;
    } tour_result_t;

    // shadow copy of the block state
    bit [DIST_W-1:0] leg_len    [NCITY][NCITY];
    bit [CITY_W-1:0] route_city [NROUTE][NCITY];
    bit [CITY_W-1:0] best_route [NCITY];
    longint          best_cost;

    tour_result_t expected_results [$];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // sum of all legs including the way back, saturated
    function automatic longint closed_tour_cost(input int ind);
        longint sum;
        int     nxt;
        sum = 0;
        for (int i = 0; i < NCITY; i++)
        begin
            nxt = (i + 1 == NCITY) ? 0 : i + 1;
            sum += leg_len[route_city[ind][i]][route_city[ind][nxt]];
            if (sum > COST_MAX)
                sum = COST_MAX;
        end
        return sum;
    endfunction

    // update the shadow state for one command and queue its response
    task automatic predict_command();
        tour_result_t    res;
        longint          cost;
        bit              better;
        bit [CITY_W-1:0] tmp;
        res = '0;
        case (req.opcode)
            OP_WR_DIST:
                if (req.from_city < NCITY && req.to_city < NCITY)
                    leg_len[req.from_city][req.to_city] = req.distance_value;
            OP_WR_CITY:
                if (req.individual < NROUTE && req.position < NCITY && req.city < NCITY)
                    route_city[req.individual][req.position] = req.city;
            OP_EVAL:
                if (req.individual < NROUTE)
                begin
                    cost   = closed_tour_cost(req.individual);
                    better = cost < best_cost;
                    if (better)
                    begin
                        best_cost  = cost;
                        best_route = route_city[req.individual];
                        gains_seen++;
                    end
                    // swap after the compare, so the best keeps the evaluated order
                    if (req.swap_first < NCITY && req.swap_second < NCITY)
                    begin
                        tmp = route_city[req.individual][req.swap_first];
                        route_city[req.individual][req.swap_first] =
                            route_city[req.individual][req.swap_second];
                        route_city[req.individual][req.swap_second] = tmp;
                    end
                    res.tour_cost = cost[OUT_COST_W-1:0];
                    res.improved  = better;
                    res.best_cost = best_cost[OUT_COST_W-1:0];
                    expected_results.push_back(res);
                    evals_seen++;
                end
            OP_RD_BEST:
            begin
                res.best_cost = best_cost[OUT_COST_W-1:0];
                res.best_city = (req.position < NCITY) ? best_route[req.position] : '0;
                expected_results.push_back(res);
                reads_seen++;
            end
            OP_RST_BEST:
                best_cost = COST_MAX;
            default:
                ;
        endcase
    endtask

    // compare one response with the oldest expectation
    task automatic check_result();
        tour_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("response with nothing expected, tour_cost", rsp.tour_cost, -1);
            return;
        end
        want = expected_results.pop_front();
        if (rsp.tour_cost !== want.tour_cost)
            report_mismatch("tour_cost", rsp.tour_cost, want.tour_cost);
        if (rsp.improved !== want.improved)
            report_mismatch("improved", rsp.improved, want.improved);
        if (rsp.best_cost !== want.best_cost)
            report_mismatch("best_cost", rsp.best_cost, want.best_cost);
        if (rsp.best_city !== want.best_city)
            report_mismatch("best_city", rsp.best_city, want.best_city);
    endtask

    // watch both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_cost = COST_MAX;
            foreach (best_route[i])
                best_route[i] = '0;
            expected_results.delete();
            pending    = 0;
            mismatches = 0;
            evals_seen = 0;
            reads_seen = 0;
            gains_seen = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_result();
            if (req.valid && req.ready)
                predict_command();
            pending = expected_results.size();
        end
    end

endmodule

`default_nettype wire

### dv/testbench.sv
`default_nettype none

module testbench import tcss_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCITY        = NUM_CITIES_DEF;
    localparam int NROUTE       = NUM_ROUTES_DEF;
    localparam int ITEM_TARGET  = 1800;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PAUSE_AT     = 600;
    localparam int HOLD_AT      = 1000;

    // opcodes the block takes and drops
    localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_C = 3'd7;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CITY_W-1:0]   from_city;
        logic [CITY_W-1:0]   to_city;
        logic [DIST_W-1:0]   distance_value;
        logic [IND_W-1:0]    individual;
        logic [CITY_W-1:0]   position;
        logic [CITY_W-1:0]   city;
        logic [CITY_W-1:0]   swap_first;
        logic [CITY_W-1:0]   swap_second;
    } tour_cmd_t;

    logic clk;
    logic rst_n;

    tcss_req_if req ();
    tcss_rsp_if rsp ();

    int mismatch_total;
    int results_pending;
    int eval_total;
    int read_total;
    int gain_total;

    bit [NCITY-1:0] route_mask [NROUTE];
    int             commands_sent;
    int             routes_loaded;
    int             burst_left;
    bit             gapless;
    bit             hold_go;
    bit             hold_done;
    int             idle_cycles;

    tour_cost_swap_search_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    tcss_tour_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .mismatches (mismatch_total),
        .pending    (results_pending),
        .evals_seen (eval_total),
        .reads_seen (read_total),
        .gains_seen (gain_total)
    );

    // clock
    initial
        clk = 1'b0;
    always #6 clk = ~clk;

    // command with every field random
    function automatic tour_cmd_t random_cmd(input logic [OPCODE_W-1:0] op);
        tour_cmd_t c;
        c.opcode         = op;
        c.from_city      = CITY_W'($urandom_range(0, 15));
        c.to_city        = CITY_W'($urandom_range(0, 15));
        c.distance_value = DIST_W'($urandom_range(0, 255));
        c.individual     = IND_W'($urandom_range(0, 63));
        c.position       = CITY_W'($urandom_range(0, 15));
        c.city           = CITY_W'($urandom_range(0, 15));
        c.swap_first     = CITY_W'($urandom_range(0, 15));
        c.swap_second    = CITY_W'($urandom_range(0, 15));
        return c;
    endfunction

    // one request transfer, with bursts and gaps on the sender side
    task automatic send_cmd(input tour_cmd_t c);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            if (!gapless)
            begin
                @(negedge clk);
                req.valid = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req.opcode         = c.opcode;
        req.from_city      = c.from_city;
        req.to_city        = c.to_city;
        req.distance_value = c.distance_value;
        req.individual     = c.individual;
        req.position       = c.position;
        req.city           = c.city;
        req.swap_first     = c.swap_first;
        req.swap_second    = c.swap_second;
        req.valid          = 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        if (c.opcode <= OP_RST_BEST)
            commands_sent++;
    endtask

    // stop offering until every response is back
    task automatic drain_wait();
        @(negedge clk);
        req.valid = 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    // write all cities of a route, either a true tour or random stops
    task automatic load_route(input int ind, input bit as_tour);
        logic [CITY_W-1:0] stops [NCITY];
        logic [CITY_W-1:0] tmp;
        tour_cmd_t         c;
        int                j;
        for (int i = 0; i < NCITY; i++)
            stops[i] = as_tour ? CITY_W'(i) : CITY_W'($urandom_range(0, NCITY - 1));
        if (as_tour)
            for (int i = NCITY - 1; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                tmp      = stops[i];
                stops[i] = stops[j];
                stops[j] = tmp;
            end
        for (int i = 0; i < NCITY; i++)
        begin
            c            = random_cmd(OP_WR_CITY);
            c.individual = IND_W'(ind);
            c.position   = CITY_W'(i);
            c.city       = stops[i];
            send_cmd(c);
        end
        route_mask[ind] = '1;
        routes_loaded++;
    endtask

    // evaluate a route, loading it first if any city is still unwritten
    task automatic eval_route(input int ind, input int s1 = -1, input int s2 = -1);
        tour_cmd_t c;
        if (route_mask[ind] != '1)
            load_route(ind, 1'($urandom_range(0, 1)));
        c            = random_cmd(OP_EVAL);
        c.individual = IND_W'(ind);
        if (s1 >= 0)
        begin
            c.swap_first  = CITY_W'(s1);
            c.swap_second = CITY_W'(s2);
        end
        else if ($urandom_range(0, 9) == 0)
            c.swap_second = c.swap_first;
        send_cmd(c);
    endtask

    task automatic read_best(input int pos);
        tour_cmd_t c;
        c          = random_cmd(OP_RD_BEST);
        c.position = CITY_W'(pos);
        send_cmd(c);
    endtask

    // mostly routes already loaded, now and then a fresh one
    function automatic int pick_route();
        int ind;
        ind = $urandom_range(0, NROUTE - 1);
        if ($urandom_range(0, 5) != 0)
            for (int k = 0; k < 64 && route_mask[ind] != '1; k++)
                ind = $urandom_range(0, NROUTE - 1);
        return ind;
    endfunction

    // receiver: one long hold when asked, otherwise a rotating stall pattern
    initial
    begin
        int unsigned stall_tick;
        rsp.ready  = 1'b0;
        stall_tick = 0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                rsp.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = 1'b1;
            end
            stall_tick++;
            case ((stall_tick / 300) % 4)
                0:       rsp.ready = 1'b1;
                1:       rsp.ready = ($urandom_range(0, 9) < 7);
                2:       rsp.ready = ((stall_tick % 5) >= 2);
                default: rsp.ready = ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin
        tour_cmd_t c;
        int        roll;
        int        ind;
        bit        paused_once;

        rst_n              = 1'b0;
        req.valid          = 1'b0;
        req.opcode         = OP_WR_DIST;
        req.from_city      = '0;
        req.to_city        = '0;
        req.distance_value = '0;
        req.individual     = '0;
        req.position       = '0;
        req.city           = '0;
        req.swap_first     = '0;
        req.swap_second    = '0;
        commands_sent      = 0;
        routes_loaded      = 0;
        burst_left         = 0;
        paused_once        = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // best state straight after reset, dropped opcodes, reset at infinity
        read_best(0);
        read_best(NCITY - 1);
        send_cmd(random_cmd(OP_SPARE_A));
        send_cmd(random_cmd(OP_SPARE_B));
        send_cmd(random_cmd(OP_SPARE_C));
        send_cmd(random_cmd(OP_RST_BEST));

        // fill the whole distance table, extremes at both corners
        for (int f = 0; f < NCITY; f++)
            for (int t = 0; t < NCITY; t++)
            begin
                c           = random_cmd(OP_WR_DIST);
                c.from_city = CITY_W'(f);
                c.to_city   = CITY_W'(t);
                if (f == 0 && t == 0)
                    c.distance_value = '1;
                else if (f == NCITY - 1 && t == NCITY - 1)
                    c.distance_value = '0;
                send_cmd(c);
            end

        // lowest and highest route, equal and extreme swap positions
        load_route(0, 1'b1);
        load_route(NROUTE - 1, 1'b0);
        eval_route(0, 5, 5);
        eval_route(0, 0, NCITY - 1);
        eval_route(NROUTE - 1, NCITY - 1, 0);
        read_best(NCITY - 1);
        read_best(0);
        send_cmd(random_cmd(OP_RST_BEST));
        read_best(7);
        eval_route(NROUTE - 1, NCITY - 1, NCITY - 1);
        eval_route(NROUTE - 1, 0, 0);
        eval_route(0);

        // random mix
        while (commands_sent < ITEM_TARGET)
        begin
            if (!paused_once && commands_sent >= PAUSE_AT)
            begin
                drain_wait();
                paused_once = 1'b1;
            end
            if (!hold_go && commands_sent >= HOLD_AT)
            begin
                // receiver holds off while evaluations keep coming
                hold_go = 1'b1;
                gapless = 1'b1;
                repeat (12) eval_route(pick_route());
                gapless = 1'b0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                ind = pick_route();
                repeat ($urandom_range(1, 3)) eval_route(ind);
            end
            else if (roll < 55)
                read_best($urandom_range(0, NCITY - 1));
            else if (roll < 67)
            begin
                c = random_cmd(OP_WR_CITY);
                route_mask[c.individual][c.position] = 1'b1;
                send_cmd(c);
            end
            else if (roll < 77)
                send_cmd(random_cmd(OP_WR_DIST));
            else if (roll < 83)
                send_cmd(random_cmd(OP_RST_BEST));
            else if (roll < 88)
                send_cmd(random_cmd(OPCODE_W'($urandom_range(OP_SPARE_A, OP_SPARE_C))));
            else if (roll < 97)
            begin
                ind = pick_route();
                load_route(ind, 1'($urandom_range(0, 1)));
                eval_route(ind);
            end
            else
                drain_wait();
        end

        // let every response come back, then the block settle
        drain_wait();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("summary: %0d commands, %0d routes loaded, %0d evaluations",
                 commands_sent, routes_loaded, eval_total);
        $display("summary: %0d new bests, %0d best-route reads", gain_total, read_total);
        if (mismatch_total == 0 && results_pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/tcss_pkg.sv
hw/rtl/tcss_req_if.sv
hw/rtl/tcss_rsp_if.sv
hw/rtl/tcss_front.sv
hw/rtl/tcss_queue.sv
hw/rtl/tcss_back.sv
hw/rtl/tour_cost_swap_search_unit.sv
dv/tcss_tour_checker.sv
dv/testbench.sv
